[hw/rtl/wrp_pkg.sv]
// Shared types and constants for the WAV RIFF/PCM header parser.
`timescale 1ns / 1ps
`default_nettype none

package wrp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [5:0]  MIN_FILE_BYTES = 6'd44;
  localparam logic [31:0] MIN_FMT_BYTES  = 32'd16;
  localparam logic [15:0] PCM_TAG        = 16'd1;
  localparam logic [31:0] HDR_BYTES      = 32'd4;
  localparam logic [4:0]  FMT_LAST_IDX   = 5'd15;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_ID,
    PH_SIZE,
    PH_FMT,
    PH_DATA,
    PH_SKIP,
    PH_PAD,
    PH_HALT
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_BAD_TAG    = 4'd2,
    ST_FMT_SMALL  = 4'd3,
    ST_NOT_PCM    = 4'd4,
    ST_NO_FMT     = 4'd5,
    ST_NO_DATA    = 4'd6,
    ST_LAYOUT     = 4'd7,
    ST_DATA_FIRST = 4'd8
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last;
    status_e     status;
    logic [1:0]  format_code;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] payload_length;
  } result_t;

  // up to two results per request, in order
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

[hw/rtl/wrp_in_if.sv]
// Input byte channel of the WAV parser.
`timescale 1ns / 1ps
`default_nettype none

interface wrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source(output valid, output file_byte, output end_of_file, input ready);
  modport sink(input valid, input file_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

[hw/rtl/wrp_out_if.sv]
// Result channel of the WAV parser.
`timescale 1ns / 1ps
`default_nettype none

interface wrp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        last;
  logic [3:0]  status;
  logic [1:0]  format_code;
  logic [31:0] sample_rate;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic [31:0] payload_length;

  modport source(
    output valid, input ready,
    output kind, output payload_byte, output last, output status, output format_code,
    output sample_rate, output channel_count, output sample_bits, output payload_length
  );
  modport sink(
    input valid, output ready,
    input kind, input payload_byte, input last, input status, input format_code,
    input sample_rate, input channel_count, input sample_bits, input payload_length
  );
endinterface

`default_nettype wire

[hw/rtl/wrp_parser.sv]
// Chunk walker: parser state, fmt capture and result generation per byte.
`timescale 1ns / 1ps
`default_nettype none

module wrp_parser import wrp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] file_byte_i,
  input  wire logic       end_of_file_i,
  output push_t           push_o
);

  phase_e      phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] rem_q, rem_d;
  logic        pad_q, pad_d;
  logic [4:0]  fidx_q, fidx_d;
  logic [15:0] ftag_q, ftag_d;
  logic [15:0] fchan_q, fchan_d;
  logic [31:0] frate_q, frate_d;
  logic [15:0] fbits_q, fbits_d;
  logic        seen_fmt_q, seen_fmt_d;
  logic        seen_data_q, seen_data_d;
  logic        seen_dbf_q, seen_dbf_d;
  status_e     err_q, err_d;
  logic        is_fmt_q, is_fmt_d;
  logic        is_data_q, is_data_d;
  logic [31:0] emit_q, emit_d;

  logic [31:0] tag_new;
  logic [31:0] rem_dec;
  logic        pay_valid;
  status_e     st;
  logic [1:0]  fc;
  result_t     pay_res;
  result_t     stat_res;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = (pos_q < MIN_FILE_BYTES) ? pos_q + 6'd1 : pos_q;
    tag_d       = tag_q;
    rem_d       = rem_q;
    pad_d       = pad_q;
    fidx_d      = fidx_q;
    ftag_d      = ftag_q;
    fchan_d     = fchan_q;
    frate_d     = frate_q;
    fbits_d     = fbits_q;
    seen_fmt_d  = seen_fmt_q;
    seen_data_d = seen_data_q;
    seen_dbf_d  = seen_dbf_q;
    err_d       = err_q;
    is_fmt_d    = is_fmt_q;
    is_data_d   = is_data_q;
    emit_d      = emit_q;
    pay_valid   = 1'b0;
    tag_new     = {file_byte_i, tag_q[31:8]};
    rem_dec     = rem_q - 32'd1;

    case (phase_q)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
        tag_d = tag_new;
        rem_d = rem_dec;
        if (rem_q == 32'd1) begin
          case (phase_q)
            PH_RIFF: begin
              if (tag_new != TAG_RIFF) begin
                err_d   = ST_BAD_TAG;
                phase_d = PH_HALT;
              end else begin
                phase_d = PH_RSIZE;
                rem_d   = HDR_BYTES;
              end
            end
            PH_RSIZE: begin
              phase_d = PH_WAVE;
              rem_d   = HDR_BYTES;
            end
            PH_WAVE: begin
              if (tag_new != TAG_WAVE) begin
                err_d   = ST_BAD_TAG;
                phase_d = PH_HALT;
              end else begin
                phase_d = PH_ID;
                rem_d   = HDR_BYTES;
              end
            end
            PH_ID: begin
              is_fmt_d  = (tag_new == TAG_FMT);
              is_data_d = (tag_new == TAG_DATA);
              phase_d   = PH_SIZE;
              rem_d     = HDR_BYTES;
            end
            default: begin
              // size field complete
              pad_d = tag_new[0];
              rem_d = tag_new;
              if (is_fmt_q) begin
                if (tag_new < MIN_FMT_BYTES) begin
                  err_d   = ST_FMT_SMALL;
                  phase_d = PH_HALT;
                end else begin
                  ftag_d  = '0;
                  fchan_d = '0;
                  frate_d = '0;
                  fbits_d = '0;
                  fidx_d  = '0;
                  phase_d = PH_FMT;
                end
              end else begin
                if (is_data_q && seen_fmt_q && !seen_data_q) begin
                  seen_data_d = 1'b1;
                  phase_d     = PH_DATA;
                end else begin
                  if (is_data_q && !seen_fmt_q) seen_dbf_d = 1'b1;
                  phase_d = PH_SKIP;
                end
                if (tag_new == '0) begin
                  phase_d = PH_ID;
                  rem_d   = HDR_BYTES;
                end
              end
            end
          endcase
        end
      end
      PH_FMT: begin
        if (!fidx_q[4]) begin
          case (fidx_q[3:0])
            4'd0:    ftag_d[7:0]    = file_byte_i;
            4'd1:    ftag_d[15:8]   = file_byte_i;
            4'd2:    fchan_d[7:0]   = file_byte_i;
            4'd3:    fchan_d[15:8]  = file_byte_i;
            4'd4:    frate_d[7:0]   = file_byte_i;
            4'd5:    frate_d[15:8]  = file_byte_i;
            4'd6:    frate_d[23:16] = file_byte_i;
            4'd7:    frate_d[31:24] = file_byte_i;
            4'd14:   fbits_d[7:0]   = file_byte_i;
            4'd15:   fbits_d[15:8]  = file_byte_i;
            default: ;
          endcase
          fidx_d = fidx_q + 5'd1;
        end
        rem_d = rem_dec;
        if (fidx_q == FMT_LAST_IDX && ftag_q != PCM_TAG) begin
          err_d   = ST_NOT_PCM;
          phase_d = PH_HALT;
        end else begin
          if (fidx_q == FMT_LAST_IDX) seen_fmt_d = 1'b1;
          if (rem_dec == '0) begin
            if (pad_q) begin
              phase_d = PH_PAD;
            end else begin
              phase_d = PH_ID;
              rem_d   = HDR_BYTES;
            end
          end
        end
      end
      PH_DATA, PH_SKIP: begin
        if (phase_q == PH_DATA) begin
          pay_valid = 1'b1;
          emit_d    = emit_q + 32'd1;
        end
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          if (pad_q) begin
            phase_d = PH_PAD;
          end else begin
            phase_d = PH_ID;
            rem_d   = HDR_BYTES;
          end
        end
      end
      PH_PAD: begin
        phase_d = PH_ID;
        rem_d   = HDR_BYTES;
      end
      default: ;
    endcase

    // final status from the updated state
    fc = 2'd0;
    if (pos_d < MIN_FILE_BYTES) begin
      st = ST_SHORT;
    end else if (err_d != ST_OK) begin
      st = err_d;
    end else if (phase_d == PH_FMT && !fidx_d[4]) begin
      st = ST_FMT_SMALL;
    end else if (!seen_fmt_d) begin
      st = ST_NO_FMT;
    end else if (!seen_data_d) begin
      st = seen_dbf_d ? ST_DATA_FIRST : ST_NO_DATA;
    end else if ((fchan_d == 16'd1 || fchan_d == 16'd2) &&
                 (fbits_d == 16'd8 || fbits_d == 16'd16)) begin
      st = ST_OK;
      fc = {fchan_d == 16'd2, fbits_d == 16'd16};  // mono8/mono16/stereo8/stereo16
    end else begin
      st = ST_LAYOUT;
    end

    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = file_byte_i;
    pay_res.last         = !end_of_file_i;

    stat_res                = '0;
    stat_res.kind           = KIND_STATUS;
    stat_res.last           = 1'b1;
    stat_res.status         = st;
    stat_res.format_code    = fc;
    stat_res.sample_rate    = frate_d;
    stat_res.channel_count  = fchan_d;
    stat_res.sample_bits    = fbits_d;
    stat_res.payload_length = emit_d;

    push_o.cnt = accept_i ? ({1'b0, pay_valid} + {1'b0, end_of_file_i}) : 2'd0;
    push_o.r0  = pay_valid ? pay_res : stat_res;
    push_o.r1  = stat_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      pos_q       <= '0;
      tag_q       <= '0;
      rem_q       <= HDR_BYTES;
      pad_q       <= 1'b0;
      fidx_q      <= '0;
      ftag_q      <= '0;
      fchan_q     <= '0;
      frate_q     <= '0;
      fbits_q     <= '0;
      seen_fmt_q  <= 1'b0;
      seen_data_q <= 1'b0;
      seen_dbf_q  <= 1'b0;
      err_q       <= ST_OK;
      is_fmt_q    <= 1'b0;
      is_data_q   <= 1'b0;
      emit_q      <= '0;
    end else if (accept_i) begin
      if (end_of_file_i) begin
        // report sent: start over for the next file
        phase_q     <= PH_RIFF;
        pos_q       <= '0;
        tag_q       <= '0;
        rem_q       <= HDR_BYTES;
        pad_q       <= 1'b0;
        fidx_q      <= '0;
        ftag_q      <= '0;
        fchan_q     <= '0;
        frate_q     <= '0;
        fbits_q     <= '0;
        seen_fmt_q  <= 1'b0;
        seen_data_q <= 1'b0;
        seen_dbf_q  <= 1'b0;
        err_q       <= ST_OK;
        is_fmt_q    <= 1'b0;
        is_data_q   <= 1'b0;
        emit_q      <= '0;
      end else begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        tag_q       <= tag_d;
        rem_q       <= rem_d;
        pad_q       <= pad_d;
        fidx_q      <= fidx_d;
        ftag_q      <= ftag_d;
        fchan_q     <= fchan_d;
        frate_q     <= frate_d;
        fbits_q     <= fbits_d;
        seen_fmt_q  <= seen_fmt_d;
        seen_data_q <= seen_data_d;
        seen_dbf_q  <= seen_dbf_d;
        err_q       <= err_d;
        is_fmt_q    <= is_fmt_d;
        is_data_q   <= is_data_d;
        emit_q      <= emit_d;
      end
    end
  end

  a_halt_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |-> err_q != ST_OK)
    else $error("halted without an error code");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MIN_FILE_BYTES)
    else $error("byte position beyond saturation");

  a_data_needs_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> seen_fmt_q && seen_data_q)
    else $error("payload phase without fmt");

endmodule

`default_nettype wire

[hw/rtl/wrp_out_queue.sv]
// Three-entry result queue between the parser and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module wrp_out_queue import wrp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire push_t  push_i,
  output logic        room_o,
  wrp_out_if.source   result_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;
  result_t    ent_q [3];
  result_t    ent_d [3];
  result_t    sh    [3];

  assign result_o.valid = (cnt_q != 2'd0);
  assign pop            = result_o.valid & result_o.ready;
  // two free entries so a payload plus status fits
  assign room_o         = (cnt_q <= 2'd1);

  always_comb begin
    base  = cnt_q - {1'b0, pop};
    sh[0] = pop ? ent_q[1] : ent_q[0];
    sh[1] = pop ? ent_q[2] : ent_q[1];
    sh[2] = ent_q[2];
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < base) begin
        ent_d[i] = sh[i];
      end else if (2'(i) == base) begin
        ent_d[i] = push_i.r0;
      end else begin
        ent_d[i] = push_i.r1;
      end
    end
    cnt_d = base + push_i.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign result_o.kind           = ent_q[0].kind;
  assign result_o.payload_byte   = ent_q[0].payload_byte;
  assign result_o.last           = ent_q[0].last;
  assign result_o.status         = ent_q[0].status;
  assign result_o.format_code    = ent_q[0].format_code;
  assign result_o.sample_rate    = ent_q[0].sample_rate;
  assign result_o.channel_count  = ent_q[0].channel_count;
  assign result_o.sample_bits    = ent_q[0].sample_bits;
  assign result_o.payload_length = ent_q[0].payload_length;

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> cnt_q <= 2'd1)
    else $error("push into a full queue");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt == 2'd2 |-> push_i.r0.kind == KIND_PAYLOAD && push_i.r1.kind == KIND_STATUS)
    else $error("result pair out of order");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.cnt == 2'd0 |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue count lost on pop");

endmodule

`default_nettype wire

[hw/rtl/wav_riff_pcm_parser.sv]
// A result enters the result queue when its byte is accepted; result_o offers the queue head.
// Throughput: one byte per cycle while the result queue has room; a file-ending payload
//   byte yields two results (payload, then status), which can hold off the input.
// The three-entry result queue sets the rate: input is taken while it holds at most one result.
// Reset (async, active low) clears parser state and empties the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module wav_riff_pcm_parser import wrp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wrp_in_if.sink    byte_i,
  wrp_out_if.source result_o
);

  push_t push;
  logic  room;
  logic  accept;

  assign byte_i.ready = room;
  assign accept       = byte_i.valid & room;

  wrp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .file_byte_i   (byte_i.file_byte),
    .end_of_file_i (byte_i.end_of_file),
    .push_o        (push)
  );

  wrp_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .room_o   (room),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
